// ===== design/bpm_pkg.sv =====
// shared types and constants of the block-to-patch map fill unit
package bpm_pkg;

  // field widths
  localparam int PIX_W     = 16;
  localparam int LOG2_W    = 3;
  localparam int BLK_N_W   = PIX_W + 1;
  localparam int IDX_W     = 11;
  localparam int ENTRY_W   = 12;
  localparam int MODE_W    = 2;
  localparam int COORD_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // highest patch index plus one that may be placed
  localparam int MAX_PATCHES = 2048;

  // map entry that marks a block with no patch
  localparam logic [ENTRY_W-1:0] ENTRY_UNUSED = 12'hFFF;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECEDENCE = 2'd3;

  // configuration reset values
  localparam logic [LOG2_W-1:0] RST_BLOCK_LOG2 = 3'd4;
  localparam logic [PIX_W-1:0]  RST_FRAME_W    = 16'd1024;
  localparam logic [PIX_W-1:0]  RST_FRAME_H    = 16'd1024;

endpackage

// ===== design/bpm_ram.sv =====
// generic single-port ram with registered read
module bpm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic                             rd_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] addr,
  input  logic [WIDTH-1:0]                 wr_data,
  output logic [WIDTH-1:0]                 rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/bpm_blk_unit.sv =====
// shared pixel-to-block round-up unit
module bpm_blk_unit import bpm_pkg::*; (
  input  logic [PIX_W-1:0]   pixels,
  input  logic [LOG2_W-1:0]  shift_amt,
  output logic [BLK_N_W-1:0] blocks
);

  logic [BLK_N_W-1:0] offset;
  logic [BLK_N_W-1:0] sum;

  // ceil(pixels / 2^shift_amt)
  assign offset = (BLK_N_W'(1) << shift_amt) - BLK_N_W'(1);
  assign sum    = {1'b0, pixels} + offset;
  assign blocks = sum >> shift_amt;

endmodule

// ===== design/block_to_patch_map_fill_unit.sv =====
// top level: block-to-patch map sequencer, map memory and result register
// reset: after rst_n the map is swept to unused, one entry a cycle, over all
//   MAX_MAP_BLOCKS_X * MAX_MAP_BLOCKS_Y entries; no item is taken meanwhile
// clear item: every map entry is swept to unused (one ram write a cycle)
// place item: setup on the shared round-up unit, then one cycle per covered block;
//   in first-wins mode each block takes a ram read, then a write only if the entry is unused
// read item: the entry is fetched from the map; one item at a time, result held in an output register
module block_to_patch_map_fill_unit import bpm_pkg::*; #(
  parameter int MAX_MAP_BLOCKS_X = 256,
  parameter int MAX_MAP_BLOCKS_Y = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration port
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DAT_W-1:0]      cfg_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic [PIX_W-1:0]          in_patch_x,
  input  logic [PIX_W-1:0]          in_patch_y,
  input  logic [PIX_W-1:0]          in_patch_w,
  input  logic [PIX_W-1:0]          in_patch_h,
  input  logic [IDX_W-1:0]          in_patch_index,
  input  logic [COORD_W-1:0]        in_block_col,
  input  logic [COORD_W-1:0]        in_block_row,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ENTRY_W-1:0] out_patch_at_block,
  output logic                      out_clipped
);

  localparam int DEPTH = MAX_MAP_BLOCKS_X * MAX_MAP_BLOCKS_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_MAP_BLOCKS_X > 1) ? $clog2(MAX_MAP_BLOCKS_X) : 1;
  localparam int YW    = (MAX_MAP_BLOCKS_Y > 1) ? $clog2(MAX_MAP_BLOCKS_Y) : 1;
  localparam int MXW   = $clog2(MAX_MAP_BLOCKS_X + 1);
  localparam int MYW   = $clog2(MAX_MAP_BLOCKS_Y + 1);
  localparam int EXT_W = PIX_W + 2;

  typedef enum logic [14:0] {
    S_INIT    = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_MAPW    = 15'b000000000000100,
    S_MAPH    = 15'b000000000001000,
    S_PW      = 15'b000000000010000,
    S_PH      = 15'b000000000100000,
    S_EXT     = 15'b000000001000000,
    S_BASE    = 15'b000000010000000,
    S_WALK    = 15'b000000100000000,
    S_WALK_WR = 15'b000001000000000,
    S_CLR     = 15'b000010000000000,
    S_RD_CHK  = 15'b000100000000000,
    S_RD_ISS  = 15'b001000000000000,
    S_RD_DAT  = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  // control registers
  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [LOG2_W-1:0]    cfg_log2_r, cfg_log2_nxt;
  logic [PIX_W-1:0]     cfg_fw_r, cfg_fw_nxt;
  logic [PIX_W-1:0]     cfg_fh_r, cfg_fh_nxt;
  logic                 cfg_prec_r, cfg_prec_nxt;

  // item and working registers
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [PIX_W-1:0]     px_r, px_nxt;
  logic [PIX_W-1:0]     py_r, py_nxt;
  logic [PIX_W-1:0]     pw_r, pw_nxt;
  logic [PIX_W-1:0]     ph_r, ph_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [COORD_W-1:0]   col_r, col_nxt;
  logic [COORD_W-1:0]   row_r, row_nxt;
  logic [MXW-1:0]       map_w_r, map_w_nxt;
  logic [MYW-1:0]       map_h_r, map_h_nxt;
  logic [BLK_N_W-1:0]   wb_r, wb_nxt;
  logic [BLK_N_W-1:0]   hb_r, hb_nxt;
  logic [PIX_W-1:0]     x0_r, x0_nxt;
  logic [PIX_W-1:0]     y0_r, y0_nxt;
  logic [MXW-1:0]       xe_r, xe_nxt;
  logic [MYW-1:0]       ye_r, ye_nxt;
  logic [XW-1:0]        xs_r, xs_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [YW-1:0]        y_r, y_nxt;
  logic [AW-1:0]        row_base_r, row_base_nxt;
  logic [ENTRY_W-1:0]   res_val_r, res_val_nxt;
  logic                 res_clip_r, res_clip_nxt;
  logic [ENTRY_W-1:0]   out_val_r, out_val_nxt;
  logic                 out_clip_r, out_clip_nxt;

  // datapath wires
  logic [PIX_W-1:0]     unit_pix;
  logic [BLK_N_W-1:0]   unit_blocks;
  logic [PIX_W-1:0]     x0_calc, y0_calc;
  logic [EXT_W-1:0]     x1_calc, y1_calc;
  logic                 clip_x, clip_y;
  logic                 place_ok;
  logic                 x_last, y_last;
  logic [AW-1:0]        walk_addr;
  logic                 rd_in_map;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic                 out_free;

  // operand select for the shared round-up unit
  always_comb begin
    case (state_r)
      S_MAPW:  unit_pix = cfg_fw_r;
      S_MAPH:  unit_pix = cfg_fh_r;
      S_PW:    unit_pix = pw_r;
      default: unit_pix = ph_r;
    endcase
  end

  bpm_blk_unit u_blk (
    .pixels    (unit_pix),
    .shift_amt (cfg_log2_r),
    .blocks    (unit_blocks)
  );

  // patch extent in blocks and clipping against the map
  assign x0_calc  = px_r >> cfg_log2_r;
  assign y0_calc  = py_r >> cfg_log2_r;
  assign x1_calc  = EXT_W'(x0_calc) + EXT_W'(wb_r);
  assign y1_calc  = EXT_W'(y0_calc) + EXT_W'(hb_r);
  assign clip_x   = x1_calc > EXT_W'(map_w_r);
  assign clip_y   = y1_calc > EXT_W'(map_h_r);
  assign place_ok = (32'(idx_r) < MAX_PATCHES) && (wb_r != '0) && (hb_r != '0);

  // walk position
  assign x_last    = (MXW'(x_r) + MXW'(1)) == xe_r;
  assign y_last    = (MYW'(y_r) + MYW'(1)) == ye_r;
  assign walk_addr = row_base_r + AW'(x_r);

  // read address check
  assign rd_in_map = (PIX_W'(col_r) < PIX_W'(map_w_r)) && (PIX_W'(row_r) < PIX_W'(map_h_r));

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    mode_nxt      = mode_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pw_nxt        = pw_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    map_w_nxt     = map_w_r;
    map_h_nxt     = map_h_r;
    wb_nxt        = wb_r;
    hb_nxt        = hb_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    xs_nxt        = xs_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    row_base_nxt  = row_base_r;
    res_val_nxt   = res_val_r;
    res_clip_nxt  = res_clip_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = addr_r;
    ram_wdata     = ENTRY_UNUSED;

    case (state_r)
      S_INIT: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt     = in_mode;
          px_nxt       = in_patch_x;
          py_nxt       = in_patch_y;
          pw_nxt       = in_patch_w;
          ph_nxt       = in_patch_h;
          idx_nxt      = in_patch_index;
          col_nxt      = in_block_col;
          row_nxt      = in_block_row;
          res_val_nxt  = ENTRY_UNUSED;
          res_clip_nxt = 1'b0;
          state_nxt    = S_MAPW;
        end
      end
      S_MAPW: begin
        map_w_nxt = (unit_blocks > BLK_N_W'(MAX_MAP_BLOCKS_X)) ?
                    MXW'(MAX_MAP_BLOCKS_X) : unit_blocks[MXW-1:0];
        state_nxt = S_MAPH;
      end
      S_MAPH: begin
        map_h_nxt = (unit_blocks > BLK_N_W'(MAX_MAP_BLOCKS_Y)) ?
                    MYW'(MAX_MAP_BLOCKS_Y) : unit_blocks[MYW-1:0];
        case (mode_r)
          MODE_CLEAR: begin
            addr_nxt  = '0;
            state_nxt = S_CLR;
          end
          MODE_PLACE: state_nxt = S_PW;
          MODE_READ:  state_nxt = S_RD_CHK;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_PW: begin
        wb_nxt    = unit_blocks;
        state_nxt = S_PH;
      end
      S_PH: begin
        hb_nxt    = unit_blocks;
        state_nxt = S_EXT;
      end
      S_EXT: begin
        if (!place_ok) begin
          state_nxt = S_DONE;
        end else begin
          res_clip_nxt = clip_x || clip_y;
          x0_nxt       = x0_calc;
          y0_nxt       = y0_calc;
          xe_nxt       = clip_x ? map_w_r : x1_calc[MXW-1:0];
          ye_nxt       = clip_y ? map_h_r : y1_calc[MYW-1:0];
          state_nxt    = S_BASE;
        end
      end
      S_BASE: begin
        if ((x0_r >= PIX_W'(xe_r)) || (y0_r >= PIX_W'(ye_r))) begin
          state_nxt = S_DONE;
        end else begin
          xs_nxt       = x0_r[XW-1:0];
          x_nxt        = x0_r[XW-1:0];
          y_nxt        = y0_r[YW-1:0];
          row_base_nxt = AW'(32'(y0_r[YW-1:0]) * MAX_MAP_BLOCKS_X);
          state_nxt    = S_WALK;
        end
      end
      S_WALK, S_WALK_WR: begin
        ram_addr  = walk_addr;
        ram_wdata = ENTRY_W'(idx_r);
        if ((state_r == S_WALK) && cfg_prec_r) begin
          // first-wins: fetch the entry before deciding
          ram_re    = 1'b1;
          state_nxt = S_WALK_WR;
        end else begin
          ram_we = !cfg_prec_r || (ram_rdata == ENTRY_UNUSED);
          state_nxt = S_WALK;
          if (x_last) begin
            x_nxt        = xs_r;
            y_nxt        = y_r + YW'(1);
            row_base_nxt = row_base_r + AW'(MAX_MAP_BLOCKS_X);
            if (y_last) begin
              state_nxt = S_DONE;
            end
          end else begin
            x_nxt = x_r + XW'(1);
          end
        end
      end
      S_CLR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_RD_CHK: begin
        if (rd_in_map) begin
          addr_nxt  = AW'(32'(row_r) * MAX_MAP_BLOCKS_X + 32'(col_r));
          state_nxt = S_RD_ISS;
        end else begin
          res_clip_nxt = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_RD_ISS: begin
        ram_re    = 1'b1;
        state_nxt = S_RD_DAT;
      end
      S_RD_DAT: begin
        res_val_nxt = ram_rdata;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_clip_nxt  = out_clip_r;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_clip_nxt  = res_clip_r;
    end
  end

  // configuration writes
  always_comb begin
    cfg_log2_nxt = cfg_log2_r;
    cfg_fw_nxt   = cfg_fw_r;
    cfg_fh_nxt   = cfg_fh_r;
    cfg_prec_nxt = cfg_prec_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOCK_LOG2: cfg_log2_nxt = cfg_wdata[LOG2_W-1:0];
        CFG_FRAME_W:    cfg_fw_nxt   = cfg_wdata[PIX_W-1:0];
        CFG_FRAME_H:    cfg_fh_nxt   = cfg_wdata[PIX_W-1:0];
        CFG_PRECEDENCE: cfg_prec_nxt = cfg_wdata[0];
        default:        cfg_prec_nxt = cfg_prec_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      cfg_log2_r  <= RST_BLOCK_LOG2;
      cfg_fw_r    <= RST_FRAME_W;
      cfg_fh_r    <= RST_FRAME_H;
      cfg_prec_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      addr_r      <= addr_nxt;
      cfg_log2_r  <= cfg_log2_nxt;
      cfg_fw_r    <= cfg_fw_nxt;
      cfg_fh_r    <= cfg_fh_nxt;
      cfg_prec_r  <= cfg_prec_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pw_r       <= pw_nxt;
    ph_r       <= ph_nxt;
    idx_r      <= idx_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    map_w_r    <= map_w_nxt;
    map_h_r    <= map_h_nxt;
    wb_r       <= wb_nxt;
    hb_r       <= hb_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    xe_r       <= xe_nxt;
    ye_r       <= ye_nxt;
    xs_r       <= xs_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    row_base_r <= row_base_nxt;
    res_val_r  <= res_val_nxt;
    res_clip_r <= res_clip_nxt;
    out_val_r  <= out_val_nxt;
    out_clip_r <= out_clip_nxt;
  end

  // map memory
  bpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .rd_en   (ram_re),
    .addr    (ram_addr),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_patch_at_block = out_val_r;
  assign out_clipped        = out_clip_r;

endmodule

// ===== design/bpm_checker.sv =====
// port-level checker for the block-to-patch map fill unit, bound to the top level
module bpm_checker import bpm_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [ENTRY_W-1:0] out_patch_at_block,
  input logic                      out_clipped
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_patch_at_block) && $stable(out_clipped))
    else $error("stalled result changed");

  // one item at a time: busy after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // clipped results carry the unused marker
  a_clip_unused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_patch_at_block == ENTRY_UNUSED)
    else $error("clipped result with a patch index");

  // entry is unused or a patch index
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_patch_at_block == ENTRY_UNUSED) || !out_patch_at_block[ENTRY_W-1])
    else $error("entry out of range");

endmodule

bind block_to_patch_map_fill_unit bpm_checker u_bpm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_patch_at_block (out_patch_at_block),
  .out_clipped        (out_clipped)
);
